@@ rtl/i2ctrf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package i2ctrf_pkg;

	// Command codes carried in the command field of an input beat.
	localparam logic [1:0] CMD_BUS    = 2'd0;
	localparam logic [1:0] CMD_LWRITE = 2'd1;
	localparam logic [1:0] CMD_LREAD  = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Reply codes towards the bus controller.
	localparam logic [1:0] REPLY_NONE = 2'd0;
	localparam logic [1:0] REPLY_ACK  = 2'd1;
	localparam logic [1:0] REPLY_NACK = 2'd2;

	localparam logic [7:0] RESET_BYTE1  = 8'hF1;
	localparam logic [7:0] RESET_BYTE2  = 8'hE2;
	localparam logic [7:0] TX_PAST_END  = 8'hFF;
	localparam logic [7:0] PTR_STEP     = 8'h01;
	localparam logic [7:0] IDX_BYTE1    = 8'd1;
	localparam logic [7:0] IDX_BYTE2    = 8'd2;

	typedef struct packed {
		logic [1:0] command;
		logic       fault;
		logic       address_match;
		logic       byte_received;
		logic       master_acked;
		logic       stop_seen;
		logic [7:0] bus_byte;
		logic [6:0] local_index;
		logic [7:0] local_data;
	} in_item_t;

	typedef struct packed {
		logic [1:0] reply;
		logic       tx_loaded;
		logic [7:0] tx_byte;
		logic       transfer_active;
		logic [7:0] local_read_data;
	} out_item_t;

	// Access request from the control logic to the store.
	typedef struct packed {
		logic       wr_en;
		logic [7:0] wr_addr;
		logic [7:0] wr_data;
		logic       rd_en;
		logic [7:0] rd_addr;
	} store_req_t;

	function automatic logic [7:0] reset_byte(input logic [7:0] idx);
		logic [7:0] val;
		val = 8'h00;
		if (idx == IDX_BYTE1) begin
			val = RESET_BYTE1;
		end else if (idx == IDX_BYTE2) begin
			val = RESET_BYTE2;
		end
		return val;
	endfunction

endpackage

`default_nettype wire

@@ rtl/i2ctrf_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

module i2ctrf_store #(
	parameter int STORE_BYTES = 128
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire i2ctrf_pkg::store_req_t req,
	output logic [7:0]               rd_data
);
	import i2ctrf_pkg::*;

	localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

	logic [7:0]             mem_q [STORE_BYTES];
	logic [STORE_BYTES-1:0] vld_q;
	logic [7:0]             mem_rd_q;
	logic                   vld_rd_q;
	logic [7:0]             addr_rd_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr[AW-1:0]] <= req.wr_data;
		end
		if (req.rd_en) begin
			mem_rd_q  <= mem_q[req.rd_addr[AW-1:0]];
			addr_rd_q <= req.rd_addr;
		end
	end

	// An entry that has never been written reads as its reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.wr_addr[AW-1:0]] <= 1'b1;
			end
			if (req.rd_en) begin
				vld_rd_q <= vld_q[req.rd_addr[AW-1:0]];
			end
		end
	end

	assign rd_data = vld_rd_q ? mem_rd_q : reset_byte(addr_rd_q);

`ifndef SYNTHESIS
	a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		req.wr_en && req.rd_en |-> req.wr_addr != req.rd_addr)
		else $error("store read and write hit the same entry");
	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		req.rd_en |-> req.rd_addr < 8'(STORE_BYTES))
		else $error("store read beyond the end");
	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		req.wr_en |-> req.wr_addr < 8'(STORE_BYTES))
		else $error("store write beyond the end");
`endif

endmodule

`default_nettype wire

@@ rtl/i2c_target_register_file.sv @@
// A result beat is offered from the result register once its input beat has left
// the first-stage registers; the next input beat is taken only after that, as
// each beat reads the store once and waits for the data of its registered read port.
// A waiting result does not block the next input beat, only the one after.
// Reset is asynchronous and active low: pointer, flags and transmit hold clear,
// and the store reads back zero except for bytes 1 and 2 at once.
`timescale 1ns / 1ps
`default_nettype none

module i2c_target_register_file #(
	parameter int STORE_BYTES = 128
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    item_valid,
	output logic                   item_stall,
	input  wire i2ctrf_pkg::in_item_t item,
	output logic                   result_valid,
	input  wire                    result_stall,
	output i2ctrf_pkg::out_item_t  result
);
	import i2ctrf_pkg::*;

	localparam logic [7:0] LIMIT = 8'(STORE_BYTES);

	logic       busy_q;
	logic [7:0] ptr_q;
	logic       pset_q;
	logic       act_q;
	logic [7:0] tx_hold_q;
	logic       result_valid_q;
	out_item_t  result_q;

	logic [1:0] reply_s1;
	logic       loaded_s1;
	logic       load_ok_s1;
	logic       active_s1;
	logic       lread_s1;

	logic       accept;
	logic       fire;
	logic [7:0] ptr_d;
	logic       pset_d;
	logic       act_d;
	logic [1:0] reply_d;
	logic       loaded_d;
	logic       load_ok_d;
	logic       lread_d;
	store_req_t req_d;
	store_req_t req;
	logic [7:0] rd_data;
	logic [7:0] tx_d;

	assign accept = item_valid && !busy_q;
	assign fire   = busy_q && (!result_valid_q || !result_stall);

	always_comb begin
		ptr_d     = ptr_q;
		pset_d    = pset_q;
		act_d     = act_q;
		reply_d   = REPLY_NONE;
		loaded_d  = 1'b0;
		load_ok_d = 1'b0;
		lread_d   = 1'b0;
		req_d     = '0;
		unique case (item.command)
			CMD_BUS: begin
				if (item.fault) begin
					act_d = 1'b0;
				end else begin
					if (item.address_match) begin
						reply_d = REPLY_ACK;
						act_d   = 1'b1;
						if (item.bus_byte[0]) begin
							loaded_d      = 1'b1;
							load_ok_d     = ptr_d < LIMIT;
							req_d.rd_addr = ptr_d;
							if (load_ok_d) begin
								ptr_d = ptr_d + PTR_STEP;
							end
						end else begin
							pset_d = 1'b0;
						end
					end else if (item.byte_received) begin
						if (!pset_d) begin
							if (item.bus_byte < LIMIT) begin
								ptr_d   = item.bus_byte;
								pset_d  = 1'b1;
								reply_d = REPLY_ACK;
							end else begin
								reply_d = REPLY_NACK;
							end
						end else if (ptr_d < LIMIT) begin
							req_d.wr_en   = 1'b1;
							req_d.wr_addr = ptr_d;
							req_d.wr_data = item.bus_byte;
							ptr_d         = ptr_d + PTR_STEP;
							reply_d       = REPLY_ACK;
						end else begin
							reply_d = REPLY_NACK;
						end
					end
					// A second load overrides the one from a read address.
					if (item.master_acked) begin
						loaded_d      = 1'b1;
						load_ok_d     = ptr_d < LIMIT;
						req_d.rd_addr = ptr_d;
						if (load_ok_d) begin
							ptr_d = ptr_d + PTR_STEP;
						end
					end
					if (item.stop_seen) begin
						act_d = 1'b0;
					end
					req_d.rd_en = loaded_d && load_ok_d;
				end
			end
			CMD_LWRITE: begin
				if ({1'b0, item.local_index} < LIMIT) begin
					req_d.wr_en   = 1'b1;
					req_d.wr_addr = {1'b0, item.local_index};
					req_d.wr_data = item.local_data;
				end
			end
			CMD_LREAD: begin
				if ({1'b0, item.local_index} < LIMIT) begin
					req_d.rd_en   = 1'b1;
					req_d.rd_addr = {1'b0, item.local_index};
					lread_d       = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		req = req_d;
		if (!accept) begin
			req = '0;
		end
	end

	i2ctrf_store #(
		.STORE_BYTES(STORE_BYTES)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rd_data(rd_data)
	);

	always_comb begin
		tx_d = tx_hold_q;
		if (loaded_s1) begin
			tx_d = load_ok_s1 ? rd_data : TX_PAST_END;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			reply_s1   <= reply_d;
			loaded_s1  <= loaded_d;
			load_ok_s1 <= load_ok_d;
			active_s1  <= act_d;
			lread_s1   <= lread_d;
		end
		if (fire) begin
			result_q.reply           <= reply_s1;
			result_q.tx_loaded       <= loaded_s1;
			result_q.tx_byte         <= tx_d;
			result_q.transfer_active <= active_s1;
			result_q.local_read_data <= lread_s1 ? rd_data : 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			ptr_q          <= 8'h00;
			pset_q         <= 1'b0;
			act_q          <= 1'b0;
			tx_hold_q      <= 8'h00;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				ptr_q  <= ptr_d;
				pset_q <= pset_d;
				act_q  <= act_d;
			end else if (fire) begin
				busy_q <= 1'b0;
			end
			if (fire) begin
				result_valid_q <= 1'b1;
				tx_hold_q      <= tx_d;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign item_stall   = busy_q;
	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q && !accept)
		else $error("beat taken while the previous one is still in flight");
	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= LIMIT)
		else $error("byte pointer ran past the end of the store");
	a_past_end_tx: assert property (@(posedge clk) disable iff (!arst_n)
		fire && loaded_s1 && !load_ok_s1 |=> result_q.tx_byte == TX_PAST_END)
		else $error("load past the end did not give the filler byte");
	a_no_store_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req.wr_en && !req.rd_en)
		else $error("store accessed while a beat is in flight");
`endif

endmodule

`default_nettype wire
